/* hdl/apcs_pkg.sv */
package apcs_pkg;

    // field widths fixed by the interface
    localparam int TMO_BITS    = 14;
    localparam int LIMIT_BITS  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int WORD_BITS   = 15;
    localparam int BYTES_BITS  = 32;
    localparam int BLOCK_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    // register reset values
    localparam logic [TMO_BITS-1:0]   SEL_TMO_RST  = 14'd30;
    localparam logic [TMO_BITS-1:0]   DRQ_TMO_RST  = 14'd500;
    localparam logic [TMO_BITS-1:0]   IRQ_TMO_RST  = 14'd10000;
    localparam logic [LIMIT_BITS-1:0] XFER_LIM_RST = 16'h8000;

    // status and register values
    localparam int            STAT_BSY_BIT = 7;
    localparam int            STAT_DRQ_BIT = 3;
    localparam logic [7:0]    STAT_XFER_MASK = 8'h88;
    localparam logic [7:0]    STAT_XFER_RDY  = 8'h08;
    localparam logic [7:0]    SEL_BASE   = 8'hA0;
    localparam logic [7:0]    TF_BASE    = 8'hE0;

    // interrupt phase codes: {drq, 0, io, cod}
    localparam logic [3:0] PHASE_DONE  = 4'h3;
    localparam logic [3:0] PHASE_ABORT = 4'h0;
    localparam logic [3:0] PHASE_DATA  = 4'hA;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEL_TMO  = 2'd0,
        CFG_DRQ_TMO  = 2'd1,
        CFG_IRQ_TMO  = 2'd2,
        CFG_XFER_LIM = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_IRQ   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_BSY_PRE  = 3'd1,
        ST_BSY_POST = 3'd2,
        ST_DRQ      = 3'd3,
        ST_IRQ      = 3'd4
    } t_seq_state;

    typedef enum logic [2:0] {
        ACT_WAIT     = 3'd0,
        ACT_SELECT   = 3'd1,
        ACT_TASKFILE = 3'd2,
        ACT_PACKET   = 3'd3,
        ACT_READ     = 3'd4,
        ACT_FINISHED = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        OUT_RUNNING  = 3'd0,
        OUT_OK       = 3'd1,
        OUT_SEL_TMO  = 3'd2,
        OUT_NO_DRQ   = 3'd3,
        OUT_IRQ_TMO  = 3'd4,
        OUT_SHORT    = 3'd5,
        OUT_ABORTED  = 3'd6,
        OUT_BAD_PHASE = 3'd7
    } t_outcome;

    typedef struct packed {
        logic [TMO_BITS-1:0]   sel_tmo;
        logic [TMO_BITS-1:0]   drq_tmo;
        logic [TMO_BITS-1:0]   irq_tmo;
        logic [LIMIT_BITS-1:0] xfer_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [7:0]            status;
        logic [1:0]            reason;
        logic [COUNT_BITS-1:0] byte_count;
        logic [BYTES_BITS-1:0] expect_bytes;
        logic [BLOCK_BITS-1:0] start_block;
        logic                  target_slave;
        logic                  already_selected;
    } t_item;

    typedef struct packed {
        t_seq_state            seq_state;
        logic [BYTES_BITS-1:0] bytes_left;
        logic [BLOCK_BITS-1:0] block_num;
        logic                  slave_sel;
    } t_ctx;

    typedef struct packed {
        t_action               action;
        logic [7:0]            reg_value;
        logic [LIMIT_BITS-1:0] limit_out;
        logic [WORD_BITS-1:0]  read_words;
        logic                  odd_left;
        t_outcome              outcome;
        logic [BYTES_BITS-1:0] remaining;
        logic [BLOCK_BITS-1:0] block;
    } t_result;

endpackage

/* hdl/apcs_step.sv */
module apcs_step #(
    parameter int CD_BITS     = 14,
    parameter int SECTOR_BITS = 11
) (
    input  apcs_pkg::t_item   i_item,
    input  apcs_pkg::t_cfg    i_cfg,
    input  apcs_pkg::t_ctx    i_ctx,
    input  logic [CD_BITS-1:0] i_cd,
    output apcs_pkg::t_ctx    o_ctx,
    output logic [CD_BITS-1:0] o_cd,
    output apcs_pkg::t_result o_res
);
    import apcs_pkg::*;

    localparam int LW = (CD_BITS > TMO_BITS) ? CD_BITS : TMO_BITS;
    localparam logic [LW-1:0] CD_MAX = LW'({CD_BITS{1'b1}});

    // clamp a timeout register to the countdown range
    function automatic logic [CD_BITS-1:0] load_count(input logic [TMO_BITS-1:0] v);
        logic [LW-1:0] v_ext;
        v_ext = LW'(v);
        if (v_ext > CD_MAX) begin
            return {CD_BITS{1'b1}};
        end
        return CD_BITS'(v_ext);
    endfunction

    logic                  busy;
    logic                  cd_out;
    logic [CD_BITS-1:0]    cd_dec;
    logic [3:0]            phase;
    logic [7:0]            slave_bit;

    // shared decodes of the sample and countdown
    assign busy      = i_item.status[STAT_BSY_BIT];
    assign cd_out    = (i_cd <= CD_BITS'(1));
    assign cd_dec    = cd_out ? '0 : i_cd - CD_BITS'(1);
    assign phase     = {i_item.status[STAT_DRQ_BIT], 1'b0, i_item.reason};
    assign slave_bit = {3'b000, i_ctx.slave_sel, 4'b0000};

    // sequencer next state and result
    always_comb begin
        o_ctx = i_ctx;
        o_cd  = i_cd;
        o_res = '0;
        o_res.action  = ACT_WAIT;
        o_res.outcome = OUT_RUNNING;

        unique case (i_item.req_type)
            REQ_START: begin
                o_ctx.bytes_left = i_item.expect_bytes;
                o_ctx.block_num  = i_item.start_block;
                o_ctx.slave_sel  = i_item.target_slave;
                if (i_item.already_selected) begin
                    o_res.action    = ACT_TASKFILE;
                    o_res.reg_value = TF_BASE | {3'b000, i_item.target_slave, 4'b0000};
                    o_res.limit_out = i_cfg.xfer_limit;
                    o_ctx.seq_state = ST_DRQ;
                    o_cd            = load_count(i_cfg.drq_tmo);
                end else begin
                    o_ctx.seq_state = ST_BSY_PRE;
                    o_cd            = load_count(i_cfg.sel_tmo);
                end
            end
            REQ_TICK: begin
                unique case (i_ctx.seq_state)
                    ST_BSY_PRE: begin
                        if (!busy) begin
                            o_res.action    = ACT_SELECT;
                            o_res.reg_value = SEL_BASE | slave_bit;
                            o_ctx.seq_state = ST_BSY_POST;
                            o_cd            = load_count(i_cfg.sel_tmo);
                        end else if (cd_out) begin
                            o_res.action    = ACT_FINISHED;
                            o_res.outcome   = OUT_SEL_TMO;
                            o_ctx.seq_state = ST_IDLE;
                            o_cd            = '0;
                        end else begin
                            o_cd = cd_dec;
                        end
                    end
                    ST_BSY_POST: begin
                        if (!busy) begin
                            o_res.action    = ACT_TASKFILE;
                            o_res.reg_value = TF_BASE | slave_bit;
                            o_res.limit_out = i_cfg.xfer_limit;
                            o_ctx.seq_state = ST_DRQ;
                            o_cd            = load_count(i_cfg.drq_tmo);
                        end else if (cd_out) begin
                            o_res.action    = ACT_FINISHED;
                            o_res.outcome   = OUT_SEL_TMO;
                            o_ctx.seq_state = ST_IDLE;
                            o_cd            = '0;
                        end else begin
                            o_cd = cd_dec;
                        end
                    end
                    ST_DRQ: begin
                        if ((i_item.status & STAT_XFER_MASK) == STAT_XFER_RDY) begin
                            o_res.action    = ACT_PACKET;
                            o_ctx.seq_state = ST_IRQ;
                            o_cd            = load_count(i_cfg.irq_tmo);
                        end else if (cd_out) begin
                            o_res.action    = ACT_FINISHED;
                            o_res.outcome   = OUT_NO_DRQ;
                            o_ctx.seq_state = ST_IDLE;
                            o_cd            = '0;
                        end else begin
                            o_cd = cd_dec;
                        end
                    end
                    ST_IRQ: begin
                        if (cd_out) begin
                            o_res.action    = ACT_FINISHED;
                            o_res.outcome   = OUT_IRQ_TMO;
                            o_ctx.seq_state = ST_IDLE;
                            o_cd            = '0;
                        end else begin
                            o_cd = cd_dec;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_IRQ: begin
                if (i_ctx.seq_state == ST_IRQ) begin
                    if (phase == PHASE_DATA) begin
                        o_res.action     = ACT_READ;
                        o_res.read_words = i_item.byte_count[COUNT_BITS-1:1];
                        o_res.odd_left   = i_item.byte_count[0];
                        o_ctx.bytes_left = (i_ctx.bytes_left > BYTES_BITS'(i_item.byte_count))
                                         ? i_ctx.bytes_left - BYTES_BITS'(i_item.byte_count)
                                         : '0;
                        o_ctx.block_num  = i_ctx.block_num
                                         + BLOCK_BITS'(i_item.byte_count >> SECTOR_BITS);
                        o_cd             = load_count(i_cfg.irq_tmo);
                    end else begin
                        o_res.action    = ACT_FINISHED;
                        o_ctx.seq_state = ST_IDLE;
                        o_cd            = '0;
                        if (phase == PHASE_DONE) begin
                            o_res.outcome = (i_ctx.bytes_left != '0) ? OUT_SHORT : OUT_OK;
                        end else if (phase == PHASE_ABORT) begin
                            o_res.outcome = OUT_ABORTED;
                        end else begin
                            o_res.outcome = OUT_BAD_PHASE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.remaining = o_ctx.bytes_left;
        o_res.block     = o_ctx.block_num;
    end

endmodule

/* hdl/atapi_packet_command_sequencer_core.sv */
// ATAPI packet command sequencer, host side, PIO data-in.
// Request channel (i_in_valid / o_in_stall): one request per accepted beat,
// a start, a one millisecond tick carrying a status sample, or a drive
// interrupt. Every request gives exactly one result on the result channel
// (o_out_valid / i_out_stall) with the action to perform, register values
// and the running byte count and block number.
// Each result is registered: in the result register, or in the one-entry
// skid buffer behind it when the receiver stalls. Throughput is one
// request per cycle while o_in_stall is low; the whole sequencer update is
// a single pass of logic from the state registers. When the receiver
// stalls the result holds, one more request is taken into the skid buffer,
// and then o_in_stall rises until the receiver drains it. Configuration
// writes (i_cfg_valid, always ready) set the three timeouts and the byte
// count limit; the user makes them only while idle; the block does not check.
// Synchronous reset returns the registers to their defaults, the sequencer
// to idle with zero counts, and empties the result path.
module atapi_packet_command_sequencer_core #(
    parameter int COUNTDOWN_BITS = 14,
    parameter int SECTOR_SHIFT   = 11
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_req_type,
    input  logic [7:0]                       i_status,
    input  logic [1:0]                       i_reason,
    input  logic [apcs_pkg::COUNT_BITS-1:0]  i_byte_count,
    input  logic [apcs_pkg::BYTES_BITS-1:0]  i_expect_bytes,
    input  logic [apcs_pkg::BLOCK_BITS-1:0]  i_start_block,
    input  logic                             i_target_slave,
    input  logic                             i_already_selected,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_action,
    output logic [7:0]                       o_reg_value,
    output logic [apcs_pkg::LIMIT_BITS-1:0]  o_limit_out,
    output logic [apcs_pkg::WORD_BITS-1:0]   o_read_words,
    output logic                             o_odd_left,
    output logic [2:0]                       o_outcome,
    output logic [apcs_pkg::BYTES_BITS-1:0]  o_remaining,
    output logic [apcs_pkg::BLOCK_BITS-1:0]  o_block,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [apcs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [apcs_pkg::LIMIT_BITS-1:0]  i_cfg_data
);
    import apcs_pkg::*;

    t_cfg                  r_cfg;
    t_ctx                  r_ctx;
    t_ctx                  n_ctx;
    logic [COUNTDOWN_BITS-1:0] r_cd;
    logic [COUNTDOWN_BITS-1:0] n_cd;
    t_item                 item;
    t_result               res;
    t_result               r_out;
    t_result               n_out;
    t_result               r_skid;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_skid_valid;
    logic                  n_skid_valid;
    logic                  accept;
    logic                  out_free;

    // request fields
    assign item.req_type         = i_req_type;
    assign item.status           = i_status;
    assign item.reason           = i_reason;
    assign item.byte_count       = i_byte_count;
    assign item.expect_bytes     = i_expect_bytes;
    assign item.start_block      = i_start_block;
    assign item.target_slave     = i_target_slave;
    assign item.already_selected = i_already_selected;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sel_tmo    <= SEL_TMO_RST;
            r_cfg.drq_tmo    <= DRQ_TMO_RST;
            r_cfg.irq_tmo    <= IRQ_TMO_RST;
            r_cfg.xfer_limit <= XFER_LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEL_TMO:  r_cfg.sel_tmo    <= i_cfg_data[TMO_BITS-1:0];
                CFG_DRQ_TMO:  r_cfg.drq_tmo    <= i_cfg_data[TMO_BITS-1:0];
                CFG_IRQ_TMO:  r_cfg.irq_tmo    <= i_cfg_data[TMO_BITS-1:0];
                CFG_XFER_LIM: r_cfg.xfer_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer update
    apcs_step #(
        .CD_BITS     (COUNTDOWN_BITS),
        .SECTOR_BITS (SECTOR_SHIFT)
    ) u_step (
        .i_item (item),
        .i_cfg  (r_cfg),
        .i_ctx  (r_ctx),
        .i_cd   (r_cd),
        .o_ctx  (n_ctx),
        .o_cd   (n_cd),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.seq_state  <= ST_IDLE;
            r_ctx.bytes_left <= '0;
            r_ctx.block_num  <= '0;
            r_ctx.slave_sel  <= 1'b0;
            r_cd             <= '0;
        end else if (accept) begin
            r_ctx <= n_ctx;
            r_cd  <= n_cd;
        end
    end

    // result register and skid buffer steering
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = accept;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!out_free && accept) begin
            r_skid <= res;
        end
    end

    // result ports
    assign o_out_valid  = r_out_valid;
    assign o_action     = r_out.action;
    assign o_reg_value  = r_out.reg_value;
    assign o_limit_out  = r_out.limit_out;
    assign o_read_words = r_out.read_words;
    assign o_odd_left   = r_out.odd_left;
    assign o_outcome    = r_out.outcome;
    assign o_remaining  = r_out.remaining;
    assign o_block      = r_out.block;

endmodule

/* hdl/apcs_checker.sv */
module apcs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [2:0]                       o_action,
    input logic [apcs_pkg::WORD_BITS-1:0]   o_read_words,
    input logic                             o_odd_left,
    input logic [2:0]                       o_outcome,
    input logic [apcs_pkg::BYTES_BITS-1:0]  o_remaining
);
    import apcs_pkg::*;

    // result path is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result path not empty after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action)
            && $stable(o_outcome) && $stable(o_remaining))
        else $error("stalled result changed");

    // request stall only while a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("request stalled with empty result register");

    // outcome only reported with the finished action
    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action != ACT_FINISHED) |-> o_outcome == OUT_RUNNING)
        else $error("outcome without finished action");

    // word count only with a data read
    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action != ACT_READ) |-> o_read_words == '0 && !o_odd_left)
        else $error("read count without data read action");

endmodule

bind atapi_packet_command_sequencer_core apcs_checker u_apcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_action     (o_action),
    .o_read_words (o_read_words),
    .o_odd_left   (o_odd_left),
    .o_outcome    (o_outcome),
    .o_remaining  (o_remaining)
);

/* dv/tb_atapi_packet_command_sequencer_core.sv */
module tb_atapi_packet_command_sequencer_core;
    import apcs_pkg::*;

    localparam int COUNTDOWN_BITS = 14;
    localparam int SECTOR_SHIFT   = 11;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_ITEMS    = 220;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // clock, reset and block inputs, all known from time zero
    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic [1:0]              i_req_type = '0;
    logic [7:0]              i_status = '0;
    logic [1:0]              i_reason = '0;
    logic [COUNT_BITS-1:0]   i_byte_count = '0;
    logic [BYTES_BITS-1:0]   i_expect_bytes = '0;
    logic [BLOCK_BITS-1:0]   i_start_block = '0;
    logic                    i_target_slave = 1'b0;
    logic                    i_already_selected = 1'b0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [LIMIT_BITS-1:0]   i_cfg_data = '0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [2:0]              o_action;
    logic [7:0]              o_reg_value;
    logic [LIMIT_BITS-1:0]   o_limit_out;
    logic [WORD_BITS-1:0]    o_read_words;
    logic                    o_odd_left;
    logic [2:0]              o_outcome;
    logic [BYTES_BITS-1:0]   o_remaining;
    logic [BLOCK_BITS-1:0]   o_block;
    logic                    o_cfg_ready;

    atapi_packet_command_sequencer_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_status           (i_status),
        .i_reason           (i_reason),
        .i_byte_count       (i_byte_count),
        .i_expect_bytes     (i_expect_bytes),
        .i_start_block      (i_start_block),
        .i_target_slave     (i_target_slave),
        .i_already_selected (i_already_selected),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_action           (o_action),
        .o_reg_value        (o_reg_value),
        .o_limit_out        (o_limit_out),
        .o_read_words       (o_read_words),
        .o_odd_left         (o_odd_left),
        .o_outcome          (o_outcome),
        .o_remaining        (o_remaining),
        .o_block            (o_block),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the registers and the sequencer state
    t_cfg                      cfg_shadow = {SEL_TMO_RST, DRQ_TMO_RST, IRQ_TMO_RST, XFER_LIM_RST};
    t_seq_state                cmd_state  = ST_IDLE;
    logic [COUNTDOWN_BITS-1:0] wait_count = '0;
    logic [BYTES_BITS-1:0]     bytes_due  = '0;
    logic [BLOCK_BITS-1:0]     cur_block  = '0;
    logic                      slave_dev  = 1'b0;

    t_item   pending_reqs [$];
    t_result seq_results_q [$];
    t_item   cur_req;
    int      phase_items = 0;
    int      n_errors = 0;
    int      n_results = 0;
    int      n_cycles = 0;
    int      tx_gap = 0, tx_calm = 0;
    int      rx_wait = 0, rx_calm = 0;
    int      hold_cnt = 0;
    int      next_hold = 150;
    logic    rx_hold = 1'b0;

    // one failing sample, true once the wait has run out
    function automatic bit countdown_expired();
        if (wait_count <= 1) begin
            wait_count = '0;
            return 1'b1;
        end
        wait_count = wait_count - 1'b1;
        return 1'b0;
    endfunction

    function automatic void end_command(inout t_result r, input t_outcome code);
        cmd_state  = ST_IDLE;
        wait_count = '0;
        r.action   = ACT_FINISHED;
        r.outcome  = code;
    endfunction

    function automatic void issue_task_file(inout t_result r);
        r.action    = ACT_TASKFILE;
        r.reg_value = TF_BASE | {3'b000, slave_dev, 4'b0000};
        r.limit_out = cfg_shadow.xfer_limit;
        cmd_state   = ST_DRQ;
        wait_count  = cfg_shadow.drq_tmo;
    endfunction

    // sequencer update for one request, giving its result
    function automatic t_result run_sequencer(input t_item it);
        t_result    r;
        logic [3:0] phase;
        r = '0;
        phase = {it.status[STAT_DRQ_BIT], 1'b0, it.reason};
        case (it.req_type)
            REQ_START: begin
                bytes_due = it.expect_bytes;
                cur_block = it.start_block;
                slave_dev = it.target_slave;
                if (it.already_selected) begin
                    issue_task_file(r);
                end else begin
                    cmd_state  = ST_BSY_PRE;
                    wait_count = cfg_shadow.sel_tmo;
                end
            end
            REQ_TICK: begin
                case (cmd_state)
                    ST_BSY_PRE: begin
                        if (!it.status[STAT_BSY_BIT]) begin
                            r.action    = ACT_SELECT;
                            r.reg_value = SEL_BASE | {3'b000, slave_dev, 4'b0000};
                            cmd_state   = ST_BSY_POST;
                            wait_count  = cfg_shadow.sel_tmo;
                        end else if (countdown_expired()) begin
                            end_command(r, OUT_SEL_TMO);
                        end
                    end
                    ST_BSY_POST: begin
                        if (!it.status[STAT_BSY_BIT]) issue_task_file(r);
                        else if (countdown_expired()) end_command(r, OUT_SEL_TMO);
                    end
                    ST_DRQ: begin
                        if ((it.status & STAT_XFER_MASK) == STAT_XFER_RDY) begin
                            r.action   = ACT_PACKET;
                            cmd_state  = ST_IRQ;
                            wait_count = cfg_shadow.irq_tmo;
                        end else if (countdown_expired()) begin
                            end_command(r, OUT_NO_DRQ);
                        end
                    end
                    ST_IRQ: begin
                        if (countdown_expired()) end_command(r, OUT_IRQ_TMO);
                    end
                    default: ;
                endcase
            end
            REQ_IRQ: begin
                if (cmd_state == ST_IRQ) begin
                    if (phase == PHASE_DONE) begin
                        end_command(r, (bytes_due != 0) ? OUT_SHORT : OUT_OK);
                    end else if (phase == PHASE_ABORT) begin
                        end_command(r, OUT_ABORTED);
                    end else if (phase != PHASE_DATA) begin
                        end_command(r, OUT_BAD_PHASE);
                    end else begin
                        // data-in phase, remaining count saturates at zero
                        r.action     = ACT_READ;
                        r.read_words = it.byte_count[COUNT_BITS-1:1];
                        r.odd_left   = it.byte_count[0];
                        bytes_due    = (bytes_due > it.byte_count) ?
                                       bytes_due - it.byte_count : '0;
                        cur_block    = cur_block + (it.byte_count >> SECTOR_SHIFT);
                        wait_count   = cfg_shadow.irq_tmo;
                    end
                end
            end
            default: ;
        endcase
        r.remaining = bytes_due;
        r.block     = cur_block;
        return r;
    endfunction

    // wait in cycles before the next request, with runs of no waiting
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            seq_results_q.push_back(run_sequencer(cur_req));
            tx_gap = draw_gap(tx_calm);
        end
        if (!i_in_valid || !o_in_stall) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                i_req_type         <= cur_req.req_type;
                i_status           <= cur_req.status;
                i_reason           <= cur_req.reason;
                i_byte_count       <= cur_req.byte_count;
                i_expect_bytes     <= cur_req.expect_bytes;
                i_start_block      <= cur_req.start_block;
                i_target_slave     <= cur_req.target_slave;
                i_already_selected <= cur_req.already_selected;
                i_in_valid         <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (o_out_valid && !i_out_stall) begin
            if (seq_results_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual action %0d",
                         $time, o_action);
                n_errors++;
            end else begin
                want = seq_results_q.pop_front();
                compare_field("action", want.action, o_action);
                compare_field("reg_value", want.reg_value, o_reg_value);
                compare_field("limit_out", want.limit_out, o_limit_out);
                compare_field("read_words", want.read_words, o_read_words);
                compare_field("odd_left", want.odd_left, o_odd_left);
                compare_field("outcome", want.outcome, o_outcome);
                compare_field("remaining", want.remaining, o_remaining);
                compare_field("block", want.block, o_block);
            end
            rx_wait = draw_gap(rx_calm);
            n_results <= n_results + 1;
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        i_out_stall <= rx_hold || (rx_wait > 0);
    end

    // long receiver hold-off so the request side backs up
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            rx_hold  <= (hold_cnt != 1);
        end else if (n_results >= next_hold) begin
            hold_cnt  <= $urandom_range(120, 250);
            rx_hold   <= 1'b1;
            next_hold <= next_hold + 600;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("tb_atapi_packet_command_sequencer_core failed");
            $finish;
        end
    end

    function automatic t_item rand_req();
        t_item it;
        it.req_type         = 2'($urandom_range(0, 3));
        it.status           = 8'($urandom);
        it.reason           = 2'($urandom);
        it.byte_count       = 16'($urandom);
        it.expect_bytes     = $urandom;
        it.start_block      = $urandom;
        it.target_slave     = 1'($urandom);
        it.already_selected = 1'($urandom);
        return it;
    endfunction

    function automatic logic [COUNT_BITS-1:0] rand_byte_count();
        case ($urandom_range(0, 5))
            0: return 16'(2048 * $urandom_range(1, 31));
            1: return 16'($urandom_range(0, 16));
            2: return 16'hFFFF;
            3: return cfg_shadow.xfer_limit;
            4: return 16'($urandom) | 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // failing samples to send in one wait, sometimes enough to run it out
    function automatic int fail_samples(input int tmo, output bit runs_out);
        int t;
        t = (tmo < 1) ? 1 : tmo;
        runs_out = (t <= 40) && ($urandom_range(0, 5) == 0);
        if (runs_out) return t;
        return $urandom_range(0, (t - 1 < 3) ? t - 1 : 3);
    endfunction

    task automatic push_req(input t_item it);
        pending_reqs.push_back(it);
        phase_items++;
    endtask

    task automatic push_start(input logic [31:0] want_bytes, input logic [31:0] blk,
                              input logic slave, input logic pre_sel);
        t_item it;
        it = rand_req();
        it.req_type         = REQ_START;
        it.expect_bytes     = want_bytes;
        it.start_block      = blk;
        it.target_slave     = slave;
        it.already_selected = pre_sel;
        push_req(it);
    endtask

    task automatic push_tick(input logic [7:0] s);
        t_item it;
        it = rand_req();
        it.req_type = REQ_TICK;
        it.status   = s;
        push_req(it);
    endtask

    task automatic push_irq(input logic [7:0] s, input logic [1:0] rsn,
                            input logic [COUNT_BITS-1:0] cnt);
        t_item it;
        it = rand_req();
        it.req_type   = REQ_IRQ;
        it.status     = s;
        it.reason     = rsn;
        it.byte_count = cnt;
        push_req(it);
    endtask

    // one well-formed command with random content and random failures
    task automatic push_command();
        logic [COUNT_BITS-1:0] counts [4];
        logic [BYTES_BITS-1:0] total;
        logic [BYTES_BITS-1:0] want_bytes;
        logic [7:0]            s;
        logic [3:0]            ph;
        int                    n_data, n_fail, i, j;
        bit                    runs_out;
        bit                    pre_sel;
        n_data = $urandom_range(0, 4);
        total = '0;
        for (i = 0; i < n_data; i++) begin
            counts[i] = rand_byte_count();
            total += counts[i];
        end
        case ($urandom_range(0, 4))
            0, 1: want_bytes = total;
            2: want_bytes = total + $urandom_range(1, 5000);
            3: want_bytes = (total > 64) ? total - $urandom_range(1, 64) : '0;
            default: want_bytes = $urandom;
        endcase
        pre_sel = ($urandom_range(0, 2) == 0);
        push_start(want_bytes, $urandom, 1'($urandom), pre_sel);

        // busy clear before and after drive select
        if (!pre_sel) begin
            for (j = 0; j < 2; j++) begin
                n_fail = fail_samples(cfg_shadow.sel_tmo, runs_out);
                for (i = 0; i < n_fail; i++) begin
                    s = 8'($urandom);
                    s[STAT_BSY_BIT] = 1'b1;
                    push_tick(s);
                end
                if (runs_out) return;
                s = 8'($urandom);
                s[STAT_BSY_BIT] = 1'b0;
                push_tick(s);
            end
        end

        // now and then abandon the command so the next start lands mid-way
        if ($urandom_range(0, 19) == 0) return;

        // data request after the packet command byte
        n_fail = fail_samples(cfg_shadow.drq_tmo, runs_out);
        for (i = 0; i < n_fail; i++) begin
            s = 8'($urandom);
            if ((s & STAT_XFER_MASK) == STAT_XFER_RDY) s[STAT_BSY_BIT] = 1'b1;
            push_tick(s);
        end
        if (runs_out) return;
        s = 8'($urandom);
        s[STAT_BSY_BIT] = 1'b0;
        s[STAT_DRQ_BIT] = 1'b1;
        push_tick(s);

        // data-in interrupts, then the closing one
        for (j = 0; j <= n_data; j++) begin
            n_fail = fail_samples(cfg_shadow.irq_tmo, runs_out);
            for (i = 0; i < n_fail; i++) push_tick(8'($urandom));
            if (runs_out) return;
            s = 8'($urandom);
            if (j < n_data) begin
                s[STAT_DRQ_BIT] = 1'b1;
                push_irq(s, 2'b10, counts[j]);
            end else begin
                case ($urandom_range(0, 7))
                    0: begin
                        s[STAT_DRQ_BIT] = 1'b0;
                        push_irq(s, 2'b00, 16'($urandom));
                    end
                    1: begin
                        do begin
                            ph = 4'($urandom) & 4'hB;
                        end while (ph == PHASE_DONE || ph == PHASE_ABORT || ph == PHASE_DATA);
                        s[STAT_DRQ_BIT] = ph[3];
                        push_irq(s, ph[1:0], 16'($urandom));
                    end
                    default: begin
                        s[STAT_DRQ_BIT] = 1'b0;
                        push_irq(s, 2'b11, 16'($urandom));
                    end
                endcase
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [LIMIT_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SEL_TMO:  cfg_shadow.sel_tmo    = val[TMO_BITS-1:0];
            CFG_DRQ_TMO:  cfg_shadow.drq_tmo    = val[TMO_BITS-1:0];
            CFG_IRQ_TMO:  cfg_shadow.irq_tmo    = val[TMO_BITS-1:0];
            CFG_XFER_LIM: cfg_shadow.xfer_limit = val;
            default: ;
        endcase
    endtask

    // every request sent and every result back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || seq_results_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [LIMIT_BITS-1:0] vals [4];
        t_item                 it;
        int                    ph, i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests at the reset register values
        push_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);  // already selected
        push_tick(8'h08);
        push_irq(8'hFF, 2'b10, 16'hFFFF);   // odd count, block number wraps
        push_irq(8'h08, 2'b10, 16'h0000);
        push_irq(8'h00, 2'b11, 16'h0000);   // done with bytes still due
        push_tick(8'h00);                   // tick while idle
        push_irq(8'h08, 2'b10, 16'h1234);   // interrupt outside its wait
        it = rand_req();
        it.req_type = REQ_UNUSED;
        push_req(it);
        push_start(32'd4096, 32'd0, 1'b0, 1'b0);
        push_tick(8'h80);
        push_tick(8'h7F);
        push_tick(8'hFF);
        push_tick(8'h00);
        push_tick(8'h80);
        push_tick(8'h00);
        push_tick(8'h88);
        push_tick(8'h08);
        push_tick(8'hA5);                   // tick during the interrupt wait
        push_irq(8'h08, 2'b10, 16'd4097);   // more than due, remaining saturates
        push_irq(8'h08, 2'b11, 16'h0000);   // bad phase
        push_start(32'd0, 32'd0, 1'b1, 1'b0);
        push_start(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);  // restart while busy
        push_tick(8'h08);
        push_irq(8'h00, 2'b11, 16'h0000);   // done, nothing due
        wait_drained();

        // random phases over several register settings
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: vals = '{16'd1, 16'd1, 16'd1, 16'd2};
                1: vals = '{16'd16383, 16'd16383, 16'd16383, 16'd65534};
                2: begin
                    vals[0] = 16'($urandom_range(1, 4));
                    vals[1] = 16'($urandom_range(1, 4));
                    vals[2] = 16'($urandom_range(1, 8));
                    vals[3] = 16'($urandom_range(2, 65534));
                end
                3: vals = '{16'(SEL_TMO_RST), 16'(DRQ_TMO_RST), 16'(IRQ_TMO_RST),
                            XFER_LIM_RST};
                default: begin
                    for (i = 0; i < 3; i++) begin
                        vals[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 8))
                                                              : 16'($urandom_range(1, 16383));
                    end
                    vals[3] = 16'($urandom_range(2, 65534));
                end
            endcase
            for (i = 0; i < 4; i++) write_reg(t_cfg_idx'(i), vals[i]);
            @(negedge i_clk);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 3)) push_req(rand_req());
                end else begin
                    push_command();
                end
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (n_errors == 0 && seq_results_q.size() == 0) begin
            $display("tb_atapi_packet_command_sequencer_core passed");
        end else begin
            $display("tb_atapi_packet_command_sequencer_core failed");
        end
        $finish;
    end

endmodule
